>>> rtl/core/hscs_pkg.sv
// ----------------------------------------------------------------------------
// Hall sensor check sequencer package
// Shared types, register map, reset values and command codes.
// ----------------------------------------------------------------------------
package hscs_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Register map
  localparam logic [CfgIdxW-1:0] CFG_TICK_THRESHOLD  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_STEP       = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DUTY_TOP        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE_TICKS    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RUN_TICKS       = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_TICKS    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_FAIL_POLL_TICKS = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_HALL_PRESET     = 3'd7;

  // Register reset values
  localparam logic [7:0]  RST_TICK_THRESHOLD  = 8'd10;
  localparam logic [7:0]  RST_DUTY_STEP       = 8'd30;
  localparam logic [9:0]  RST_DUTY_TOP        = 10'd800;
  localparam logic [15:0] RST_SETTLE_TICKS    = 16'd100;
  localparam logic [15:0] RST_RUN_TICKS       = 16'd300;
  localparam logic [7:0]  RST_SAMPLE_TICKS    = 8'd10;
  localparam logic [15:0] RST_FAIL_POLL_TICKS = 16'd20;
  localparam logic [15:0] RST_HALL_PRESET     = 16'd20000;

  // Motor command codes
  localparam logic [1:0] MOTOR_NONE  = 2'd0;
  localparam logic [1:0] MOTOR_DRIVE = 2'd1;
  localparam logic [1:0] MOTOR_STOP  = 2'd2;

  // Buzzer mode write codes
  localparam logic [1:0] BUZ_MODE_KEEP = 2'd0;
  localparam logic [1:0] BUZ_MODE_0    = 2'd1;
  localparam logic [1:0] BUZ_MODE_1    = 2'd2;

  // Beep counts
  localparam logic [3:0] BEEP_CLEAR = 4'd0;
  localparam logic [3:0] BEEP_START = 4'd1;
  localparam logic [3:0] BEEP_DONE  = 4'd3;
  localparam logic [3:0] BEEP_FAIL  = 4'd10;

  // Stored verdict
  localparam logic [1:0] VERDICT_NONE = 2'd0;
  localparam logic [1:0] VERDICT_PASS = 2'd1;
  localparam logic [1:0] VERDICT_FAIL = 2'd2;

  // Sequencer steps
  localparam logic [3:0] ST_WAIT_START = 4'd0;
  localparam logic [3:0] ST_PRESET     = 4'd1;
  localparam logic [3:0] ST_SETTLE_FWD = 4'd2;
  localparam logic [3:0] ST_RAMP_UP_F  = 4'd3;
  localparam logic [3:0] ST_RUN_FWD    = 4'd4;
  localparam logic [3:0] ST_RAMP_DN_F  = 4'd5;
  localparam logic [3:0] ST_SETTLE_REV = 4'd6;
  localparam logic [3:0] ST_RAMP_UP_R  = 4'd7;
  localparam logic [3:0] ST_RUN_REV    = 4'd8;
  localparam logic [3:0] ST_RAMP_DN_R  = 4'd9;
  localparam logic [3:0] ST_SETTLE_END = 4'd10;
  localparam logic [3:0] ST_FAIL       = 4'd11;

  typedef struct packed {
    logic [7:0]  tick_threshold;
    logic [7:0]  duty_step;
    logic [9:0]  duty_top;
    logic [15:0] settle_ticks;
    logic [15:0] run_ticks;
    logic [7:0]  sample_ticks;
    logic [15:0] fail_poll_ticks;
    logic [15:0] hall_preset;
  } hscs_cfg_t;

  typedef struct packed {
    logic [7:0]  elapsed_ms;
    logic        start_switch;
    logic        release_switch;
    logic [15:0] hall_count;
  } hscs_poll_t;

  typedef struct packed {
    logic        stepped;
    logic        led_pass;
    logic        led_fail;
    logic [1:0]  motor_cmd;
    logic        motor_dir;
    logic [10:0] motor_duty;
    logic        hall_load;
    logic        buzzer_write;
    logic [3:0]  buzzer_count;
    logic [1:0]  beep_mode;
    logic        loopback_set;
    logic [3:0]  test_step;
  } hscs_result_t;

endpackage

>>> rtl/core/hscs_poll_if.sv
// ----------------------------------------------------------------------------
// Poll channel
// Valid/ready channel carrying one poll beat into the sequencer.
// ----------------------------------------------------------------------------
interface hscs_poll_if;
  logic        valid;
  logic        ready;
  logic [7:0]  elapsed_ms;
  logic        start_switch;
  logic        release_switch;
  logic [15:0] hall_count;

  modport source (
    output valid, elapsed_ms, start_switch, release_switch, hall_count,
    input  ready
  );

  modport sink (
    input  valid, elapsed_ms, start_switch, release_switch, hall_count,
    output ready
  );
endinterface

>>> rtl/core/hscs_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result beat with the command fields.
// ----------------------------------------------------------------------------
interface hscs_result_if;
  logic        valid;
  logic        ready;
  logic        stepped;
  logic        led_pass;
  logic        led_fail;
  logic [1:0]  motor_cmd;
  logic        motor_dir;
  logic [10:0] motor_duty;
  logic        hall_load;
  logic        buzzer_write;
  logic [3:0]  buzzer_count;
  logic [1:0]  beep_mode;
  logic        loopback_set;
  logic [3:0]  test_step;

  modport source (
    output valid, stepped, led_pass, led_fail, motor_cmd, motor_dir, motor_duty,
           hall_load, buzzer_write, buzzer_count, beep_mode, loopback_set,
           test_step,
    input  ready
  );

  modport sink (
    input  valid, stepped, led_pass, led_fail, motor_cmd, motor_dir, motor_duty,
           hall_load, buzzer_write, buzzer_count, beep_mode, loopback_set,
           test_step,
    output ready
  );
endinterface

>>> rtl/core/hscs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file holding the sequencer timing and ramp settings.
// ----------------------------------------------------------------------------
module hscs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hscs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hscs_pkg::CfgDataW-1:0] cfg_data_i,
  output hscs_pkg::hscs_cfg_t           cfg_o
);
  import hscs_pkg::*;

  hscs_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_threshold  <= RST_TICK_THRESHOLD;
      cfg_q.duty_step       <= RST_DUTY_STEP;
      cfg_q.duty_top        <= RST_DUTY_TOP;
      cfg_q.settle_ticks    <= RST_SETTLE_TICKS;
      cfg_q.run_ticks       <= RST_RUN_TICKS;
      cfg_q.sample_ticks    <= RST_SAMPLE_TICKS;
      cfg_q.fail_poll_ticks <= RST_FAIL_POLL_TICKS;
      cfg_q.hall_preset     <= RST_HALL_PRESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TICK_THRESHOLD:  cfg_q.tick_threshold  <= cfg_data_i[7:0];
        CFG_DUTY_STEP:       cfg_q.duty_step       <= cfg_data_i[7:0];
        CFG_DUTY_TOP:        cfg_q.duty_top        <= cfg_data_i[9:0];
        CFG_SETTLE_TICKS:    cfg_q.settle_ticks    <= cfg_data_i;
        CFG_RUN_TICKS:       cfg_q.run_ticks       <= cfg_data_i;
        CFG_SAMPLE_TICKS:    cfg_q.sample_ticks    <= cfg_data_i[7:0];
        CFG_FAIL_POLL_TICKS: cfg_q.fail_poll_ticks <= cfg_data_i;
        CFG_HALL_PRESET:     cfg_q.hall_preset     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/hscs_seq.sv
// ----------------------------------------------------------------------------
// Self-test sequencer
// Holds the test state and works out one poll per cycle when item_en_i is set:
// LED update, step transition, timers and the command fields of the result.
// ----------------------------------------------------------------------------
module hscs_seq (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    item_en_i,
  input  hscs_pkg::hscs_poll_t    poll_i,
  input  hscs_pkg::hscs_cfg_t     cfg_i,
  output hscs_pkg::hscs_result_t  res_o
);
  import hscs_pkg::*;

  logic [3:0]  step_q, step_d;
  logic [15:0] long_q, long_d;
  logic [7:0]  samp_q, samp_d;
  logic [15:0] prev_q, prev_d;
  logic [10:0] duty_q, duty_d;
  logic        fail_q, fail_d;
  logic [1:0]  verdict_q, verdict_d;
  logic [1:0]  led_q, led_d;

  logic [15:0] long_lim;
  logic        long_fire;
  logic [15:0] long_next;
  logic        samp_fire;
  logic [7:0]  samp_next;
  logic        do_step;
  logic [3:0]  step_inc;
  logic        sample_ok;
  hscs_result_t res;

  // The long timer compares against a limit picked by the current step.
  always_comb begin
    priority if (step_q == ST_RUN_FWD || step_q == ST_RUN_REV) begin
      long_lim = cfg_i.run_ticks;
    end else if (step_q == ST_FAIL) begin
      long_lim = cfg_i.fail_poll_ticks;
    end else begin
      long_lim = cfg_i.settle_ticks;
    end
  end

  assign long_fire = long_q > long_lim;
  assign long_next = long_fire ? 16'd0 : long_q + 16'd1;
  assign samp_fire = samp_q > cfg_i.sample_ticks;
  assign samp_next = samp_fire ? 8'd0 : samp_q + 8'd1;
  assign do_step   = poll_i.elapsed_ms >= cfg_i.tick_threshold;
  assign step_inc  = step_q + 4'd1;
  assign sample_ok = (step_q == ST_RUN_FWD) ? (prev_q < poll_i.hall_count)
                                            : (prev_q > poll_i.hall_count);

  always_comb begin
    step_d    = step_q;
    long_d    = long_q;
    samp_d    = samp_q;
    prev_d    = prev_q;
    duty_d    = duty_q;
    fail_d    = fail_q;
    verdict_d = verdict_q;
    led_d     = led_q;
    res       = '0;

    if (do_step) begin
      res.stepped = 1'b1;
      if (verdict_q == VERDICT_PASS) begin
        led_d[0] = 1'b1;
      end else if (verdict_q == VERDICT_FAIL) begin
        led_d[1] = 1'b1;
      end else begin
        led_d = 2'b00;
      end

      unique case (step_q)
        ST_WAIT_START: begin
          if (!poll_i.start_switch) begin
            res.buzzer_write = 1'b1;
            res.buzzer_count = BEEP_START;
            step_d           = ST_PRESET;
            verdict_d        = VERDICT_NONE;
          end
        end
        ST_PRESET: begin
          fail_d        = 1'b0;
          long_d        = 16'd0;
          samp_d        = 8'd0;
          res.hall_load = 1'b1;
          prev_d        = cfg_i.hall_preset;
          step_d        = ST_SETTLE_FWD;
        end
        ST_SETTLE_FWD: begin
          long_d = long_next;
          if (long_fire) begin
            samp_d = 8'd0;
            duty_d = 11'd0;
            step_d = ST_RAMP_UP_F;
          end
        end
        ST_RAMP_UP_F, ST_RAMP_UP_R: begin
          if (duty_q < {1'b0, cfg_i.duty_top}) begin
            duty_d         = duty_q + {3'b000, cfg_i.duty_step};
            res.motor_cmd  = MOTOR_DRIVE;
            res.motor_dir  = (step_q == ST_RAMP_UP_F);
            res.motor_duty = duty_d;
          end else begin
            prev_d = poll_i.hall_count;
            long_d = 16'd0;
            samp_d = 8'd0;
            if (step_q == ST_RAMP_UP_F) begin
              fail_d = 1'b0;
            end
            step_d = step_inc;
          end
        end
        ST_RUN_FWD, ST_RUN_REV: begin
          // Run-length and sample checks both apply in the same step.
          long_d = long_next;
          samp_d = samp_next;
          if (long_fire) begin
            step_d = step_inc;
          end
          if (samp_fire) begin
            if (sample_ok) begin
              prev_d = poll_i.hall_count;
            end else begin
              fail_d = 1'b1;
              step_d = step_inc;
            end
          end
        end
        ST_RAMP_DN_F, ST_RAMP_DN_R: begin
          if (duty_q > {3'b000, cfg_i.duty_step}) begin
            duty_d         = duty_q - {3'b000, cfg_i.duty_step};
            res.motor_cmd  = MOTOR_DRIVE;
            res.motor_dir  = (step_q == ST_RAMP_DN_F);
            res.motor_duty = duty_d;
          end else begin
            res.motor_cmd    = MOTOR_STOP;
            res.loopback_set = 1'b1;
            if (step_q == ST_RAMP_DN_R) begin
              res.buzzer_write = 1'b1;
              res.buzzer_count = BEEP_DONE;
            end
            long_d = 16'd0;
            samp_d = 8'd0;
            duty_d = 11'd0;
            if (fail_q) begin
              step_d = ST_FAIL;
            end else if (step_q == ST_RAMP_DN_F) begin
              step_d = ST_SETTLE_REV;
            end else begin
              step_d = ST_SETTLE_END;
            end
          end
        end
        ST_SETTLE_REV: begin
          long_d = long_next;
          if (long_fire) begin
            step_d = ST_RAMP_UP_R;
          end
        end
        ST_SETTLE_END: begin
          long_d = long_next;
          if (long_fire) begin
            samp_d    = 8'd0;
            step_d    = ST_WAIT_START;
            verdict_d = VERDICT_PASS;
          end
        end
        ST_FAIL: begin
          long_d = long_next;
          if (long_fire) begin
            res.buzzer_write = 1'b1;
            if (!poll_i.release_switch) begin
              res.beep_mode    = BUZ_MODE_0;
              res.buzzer_count = BEEP_CLEAR;
              step_d           = ST_WAIT_START;
              verdict_d        = VERDICT_NONE;
            end else begin
              res.beep_mode    = BUZ_MODE_1;
              res.buzzer_count = BEEP_FAIL;
              verdict_d        = VERDICT_FAIL;
            end
          end
        end
        default: begin
          fail_d = 1'b0;
          long_d = 16'd0;
          samp_d = 8'd0;
          duty_d = 11'd0;
          step_d = ST_WAIT_START;
        end
      endcase
    end

    res.led_pass  = led_d[0];
    res.led_fail  = led_d[1];
    res.test_step = step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= ST_WAIT_START;
      long_q    <= 16'd0;
      samp_q    <= 8'd0;
      prev_q    <= 16'd0;
      duty_q    <= 11'd0;
      fail_q    <= 1'b0;
      verdict_q <= VERDICT_NONE;
      led_q     <= 2'b00;
    end else if (item_en_i) begin
      step_q    <= step_d;
      long_q    <= long_d;
      samp_q    <= samp_d;
      prev_q    <= prev_d;
      duty_q    <= duty_d;
      fail_q    <= fail_d;
      verdict_q <= verdict_d;
      led_q     <= led_d;
    end
  end

  assign res_o = res;

`ifndef SYNTHESIS
  // Steps twelve to fifteen are never entered, so the step stays in range.
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= ST_FAIL)
    else $error("sequencer step out of range");

  // Duty only changes while ramping or when a ramp ends.
  a_duty_zero_settle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_en_i && (step_q == ST_SETTLE_REV || step_q == ST_SETTLE_END
                   || step_q == ST_FAIL)) |=> duty_q == 11'd0)
    else $error("duty not zero outside of ramp and run");

  // The stored verdict is always one of its three defined codes.
  a_verdict_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (verdict_q == VERDICT_NONE || verdict_q == VERDICT_PASS
     || verdict_q == VERDICT_FAIL))
    else $error("stored verdict has an undefined code");
`endif

endmodule

>>> rtl/core/hall_sensor_check_sequencer_top.sv
// ----------------------------------------------------------------------------
// Hall sensor check sequencer
// Motor self-test sequencer driven by millisecond polls; emits LED, motor,
// buzzer, hall preset and loopback commands as one result beat per poll.
// ----------------------------------------------------------------------------
// Path: a poll beat is held in the poll register, and its result beat is held
// in the result register until result_o takes it.
// One poll per cycle unless the result register is held; the step logic is a
// single pass from poll register to result register, updating state in it.
// Reset: rst_ni clears the sequencer state and loads the register defaults.
module hall_sensor_check_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hscs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hscs_pkg::CfgDataW-1:0] cfg_data_i,
  hscs_poll_if.sink                     poll_i,
  hscs_result_if.source                 result_o
);
  import hscs_pkg::*;

  hscs_cfg_t    cfg;
  hscs_poll_t   poll_q;
  logic         poll_vld_q;
  logic         work_go;
  hscs_result_t res;
  hscs_result_t res_q;
  logic         res_vld_q;

  hscs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The held poll moves on whenever the result register is free or drains.
  assign work_go      = poll_vld_q && (!res_vld_q || result_o.ready);
  assign poll_i.ready = !poll_vld_q || work_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_vld_q <= 1'b0;
    end else if (poll_i.ready) begin
      poll_vld_q <= poll_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (poll_i.valid && poll_i.ready) begin
      poll_q.elapsed_ms     <= poll_i.elapsed_ms;
      poll_q.start_switch   <= poll_i.start_switch;
      poll_q.release_switch <= poll_i.release_switch;
      poll_q.hall_count     <= poll_i.hall_count;
    end
  end

  hscs_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_en_i (work_go),
    .poll_i    (poll_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (!res_vld_q || result_o.ready) begin
      res_vld_q <= work_go;
    end
  end

  always_ff @(posedge clk_i) begin
    if (work_go) begin
      res_q <= res;
    end
  end

  assign result_o.valid        = res_vld_q;
  assign result_o.stepped      = res_q.stepped;
  assign result_o.led_pass     = res_q.led_pass;
  assign result_o.led_fail     = res_q.led_fail;
  assign result_o.motor_cmd    = res_q.motor_cmd;
  assign result_o.motor_dir    = res_q.motor_dir;
  assign result_o.motor_duty   = res_q.motor_duty;
  assign result_o.hall_load    = res_q.hall_load;
  assign result_o.buzzer_write = res_q.buzzer_write;
  assign result_o.buzzer_count = res_q.buzzer_count;
  assign result_o.beep_mode    = res_q.beep_mode;
  assign result_o.loopback_set = res_q.loopback_set;
  assign result_o.test_step    = res_q.test_step;

`ifndef SYNTHESIS
  // A held poll that cannot move on must still be held next cycle.
  a_poll_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (poll_vld_q && !work_go) |=> poll_vld_q)
    else $error("held poll beat dropped");

  // A poll below the tick threshold issues no commands.
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && !res_q.stepped) |-> (res_q.motor_cmd == MOTOR_NONE
      && !res_q.hall_load && !res_q.buzzer_write && !res_q.loopback_set))
    else $error("command issued without a step");

  // Direction and duty travel only with a drive command.
  a_drive_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.motor_cmd != MOTOR_DRIVE)
      |-> (res_q.motor_duty == 11'd0 && !res_q.motor_dir))
    else $error("motor data without drive command");
`endif

endmodule
